>>> sv/oets_pkg.sv
package oets_pkg;

  // Sequencer states of the sorter.
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_CMP,
    ST_WR2,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

endpackage

>>> sv/odd_even_transposition_sorter.sv
// Odd-even transposition sorter. Signed values are loaded one beat per cycle
// until the beat marked last; beats beyond MAX_ELEMENTS are dropped and every
// result of that set then carries overflow. The set is sorted in place in a
// single-ported-write buffer by one shared comparator: each compare-swap of a
// pair goes through a check state and a compare state, and a swapped pair also
// through a second write state; rounds of an odd pass followed by an even pass
// repeat until a round makes no swap. Results then leave in ascending order,
// each read, loaded and held until accepted before the next is read, the final
// one marked by final_res. No new input is taken from the last beat of a set
// until the final result of that set has been accepted.
module odd_even_transposition_sorter #(
  parameter int MAX_ELEMENTS = 16,
  parameter int DATA_WIDTH   = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] value,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] sorted_value,
  output logic                         final_res,
  output logic                         overflow
);

  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int IW = $clog2(MAX_ELEMENTS);
  localparam int XW = $clog2(MAX_ELEMENTS + 2);

  oets_pkg::state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic          dropped, dropped_next;
  logic          swapped, swapped_next;
  logic          odd_phase, odd_next;
  logic [XW-1:0] idx, idx_next;
  logic [CW-1:0] k, k_next;

  logic [XW-1:0]         idx_inc;
  logic [XW-1:0]         idx_step;
  logic                  pair_ok;
  logic                  we;
  logic [IW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic                  re;
  logic [IW-1:0]         raddr0;
  logic [IW-1:0]         raddr1;
  logic [DATA_WIDTH-1:0] rd0;
  logic [DATA_WIDTH-1:0] rd1;
  logic                  gt;
  logic                  out_load;

  oets_ram #(
    .DEPTH (MAX_ELEMENTS),
    .WIDTH (DATA_WIDTH)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (re),
    .raddr0 (raddr0),
    .raddr1 (raddr1),
    .rdata0 (rd0),
    .rdata1 (rd1)
  );

  oets_cmp #(
    .WIDTH (DATA_WIDTH)
  ) u_cmp (
    .a  ($signed(rd0)),
    .b  ($signed(rd1)),
    .gt (gt)
  );

  assign idx_inc  = idx + XW'(1);
  assign idx_step = idx + XW'(2);
  assign pair_ok  = ((XW + 1)'(idx) + (XW + 1)'(1)) < (XW + 1)'(count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= oets_pkg::ST_LOAD;
      count     <= '0;
      dropped   <= 1'b0;
      swapped   <= 1'b0;
      odd_phase <= 1'b0;
      idx       <= '0;
      k         <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      dropped   <= dropped_next;
      swapped   <= swapped_next;
      odd_phase <= odd_next;
      idx       <= idx_next;
      k         <= k_next;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      sorted_value <= $signed(rd0);
      final_res    <= (k + CW'(1)) == count;
      overflow     <= dropped;
    end
  end

  assign out_valid = (state == oets_pkg::ST_EMIT_WAIT);

  always_comb begin
    state_next   = state;
    count_next   = count;
    dropped_next = dropped;
    swapped_next = swapped;
    odd_next     = odd_phase;
    idx_next     = idx;
    k_next       = k;
    we           = 1'b0;
    waddr        = idx[IW-1:0];
    wdata        = rd0;
    re           = 1'b0;
    raddr0       = idx[IW-1:0];
    raddr1       = idx_inc[IW-1:0];
    out_load     = 1'b0;
    in_ready     = 1'b0;

    case (state)
      oets_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (count < CW'(MAX_ELEMENTS)) begin
            we         = 1'b1;
            waddr      = count[IW-1:0];
            wdata      = value;
            count_next = count + CW'(1);
          end else begin
            dropped_next = 1'b1;
          end
          if (last) begin
            odd_next     = 1'b1;
            idx_next     = XW'(1);
            swapped_next = 1'b0;
            state_next   = oets_pkg::ST_CHECK;
          end
        end
      end

      oets_pkg::ST_CHECK: begin
        if (pair_ok) begin
          re         = 1'b1;
          state_next = oets_pkg::ST_CMP;
        end else if (odd_phase) begin
          odd_next = 1'b0;
          idx_next = '0;
        end else if (swapped) begin
          odd_next     = 1'b1;
          idx_next     = XW'(1);
          swapped_next = 1'b0;
        end else begin
          k_next     = '0;
          state_next = oets_pkg::ST_EMIT_RD;
        end
      end

      oets_pkg::ST_CMP: begin
        if (gt) begin
          // Lower entry takes the smaller value now, the upper one next cycle.
          we         = 1'b1;
          wdata      = rd1;
          state_next = oets_pkg::ST_WR2;
        end else begin
          idx_next   = idx_step;
          state_next = oets_pkg::ST_CHECK;
        end
      end

      oets_pkg::ST_WR2: begin
        we           = 1'b1;
        waddr        = idx_inc[IW-1:0];
        wdata        = rd0;
        swapped_next = 1'b1;
        idx_next     = idx_step;
        state_next   = oets_pkg::ST_CHECK;
      end

      oets_pkg::ST_EMIT_RD: begin
        re         = 1'b1;
        raddr0     = k[IW-1:0];
        state_next = oets_pkg::ST_EMIT_LD;
      end

      oets_pkg::ST_EMIT_LD: begin
        out_load   = 1'b1;
        state_next = oets_pkg::ST_EMIT_WAIT;
      end

      oets_pkg::ST_EMIT_WAIT: begin
        if (out_ready) begin
          if (final_res) begin
            count_next   = '0;
            dropped_next = 1'b0;
            state_next   = oets_pkg::ST_LOAD;
          end else begin
            k_next     = k + CW'(1);
            state_next = oets_pkg::ST_EMIT_RD;
          end
        end
      end

      default: begin
        state_next = oets_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

>>> sv/oets_ram.sv
module oets_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr0,
  input  logic [$clog2(DEPTH)-1:0] raddr1,
  output logic [WIDTH-1:0]         rdata0,
  output logic [WIDTH-1:0]         rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Both read ports are registered and hold their data until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
    end
  end

endmodule

>>> sv/oets_cmp.sv
module oets_cmp #(
  parameter int WIDTH = 32
) (
  input  logic signed [WIDTH-1:0] a,
  input  logic signed [WIDTH-1:0] b,
  output logic                    gt
);

  // Strictly greater only, so equal values keep their order.
  assign gt = (a > b);

endmodule

>>> verif/tb_odd_even_transposition_sorter.sv
module tb_odd_even_transposition_sorter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY     = 16;
  localparam int WIDTH        = 32;
  localparam int HALF_PERIOD  = 10;
  localparam int RANDOM_ITEMS = 200;
  localparam int TAIL_START   = 170;
  localparam int HOLD_AT_ITEM = 50;
  localparam int LONG_HOLD    = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 40;

  localparam logic signed [WIDTH-1:0] MOST_NEG = 32'sh8000_0000;
  localparam logic signed [WIDTH-1:0] MOST_POS = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [WIDTH-1:0] value;
    logic                    fin;
    logic                    ovf;
  } sorted_beat_t;

  typedef struct packed {
    logic signed [WIDTH-1:0] value;
    logic                    last;
    logic                    fixed_exp;
    logic signed [WIDTH-1:0] want;
  } dir_row_t;

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic signed [WIDTH-1:0] value;
  logic                    last;
  logic                    out_valid;
  logic                    out_ready;
  logic signed [WIDTH-1:0] sorted_value;
  logic                    final_res;
  logic                    overflow;

  sorted_beat_t            expected_beats[$];
  dir_row_t                dir_rows[$];
  logic signed [WIDTH-1:0] set_store[CAPACITY];
  int                      set_len;
  bit                      set_dropped;
  int                      error_count;
  int                      idle_cycles;
  bit                      tail_phase;
  bit                      long_hold_go;

  odd_even_transposition_sorter #(
    .MAX_ELEMENTS(CAPACITY),
    .DATA_WIDTH  (WIDTH)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .value       (value),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sorted_value(sorted_value),
    .final_res   (final_res),
    .overflow    (overflow)
  );

  always #(HALF_PERIOD) clk = ~clk;

  task automatic report_mismatch(input string field, input logic [WIDTH-1:0] got,
                                 input logic [WIDTH-1:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, field, got, want);
    error_count++;
  endtask

  // Adds one accepted value to the set being collected; on the last beat the
  // set is sorted by odd-even transposition and its results are queued.
  task automatic collect_value(input logic signed [WIDTH-1:0] v, input logic l);
    int                      i;
    bit                      swapped;
    logic signed [WIDTH-1:0] t;
    sorted_beat_t            b;
    if (set_len < CAPACITY) begin
      set_store[set_len] = v;
      set_len++;
    end else begin
      set_dropped = 1'b1;
    end
    if (!l) return;
    do begin
      swapped = 1'b0;
      for (i = 1; i + 1 < set_len; i += 2) begin
        if (set_store[i] > set_store[i+1]) begin
          t = set_store[i];
          set_store[i] = set_store[i+1];
          set_store[i+1] = t;
          swapped = 1'b1;
        end
      end
      for (i = 0; i + 1 < set_len; i += 2) begin
        if (set_store[i] > set_store[i+1]) begin
          t = set_store[i];
          set_store[i] = set_store[i+1];
          set_store[i+1] = t;
          swapped = 1'b1;
        end
      end
    end while (swapped);
    for (i = 0; i < set_len; i++) begin
      b.value = set_store[i];
      b.fin   = (i + 1 == set_len);
      b.ovf   = set_dropped;
      expected_beats.insert(expected_beats.size(), b);
    end
    set_len = 0;
    set_dropped = 1'b0;
  endtask

  function automatic logic signed [WIDTH-1:0] pick_value(input int mode);
    logic signed [WIDTH-1:0] v;
    case ($urandom_range(0, 2) == 0 ? 3 : mode)
      0: v = $urandom;
      1: v = $urandom_range(0, 7) - 4;
      2: begin
        case ($urandom_range(0, 5))
          0: v = MOST_NEG;
          1: v = MOST_POS;
          2: v = MOST_NEG + 1;
          3: v = MOST_POS - 1;
          4: v = '0;
          default: v = '1;
        endcase
      end
      default: v = $urandom_range(0, 1) ? $urandom : ($urandom_range(0, 255) - 128);
    endcase
    return v;
  endfunction

  // Entered at a falling edge; leaves at the falling edge after the beat is taken.
  task automatic send_beat(input logic signed [WIDTH-1:0] v, input logic l,
                           input logic fixed_exp, input logic signed [WIDTH-1:0] want);
    sorted_beat_t b;
    if (!tail_phase && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    last     <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (fixed_exp) begin
      b.value = want;
      b.fin   = 1'b1;
      b.ovf   = 1'b0;
      expected_beats.insert(expected_beats.size(), b);
    end else begin
      collect_value(v, l);
    end
    @(negedge clk);
  endtask

  function automatic void add_row(input logic signed [WIDTH-1:0] v, input logic l,
                                  input logic fixed_exp, input logic signed [WIDTH-1:0] want);
    dir_row_t r;
    r.value     = v;
    r.last      = l;
    r.fixed_exp = fixed_exp;
    r.want      = want;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  initial begin
    int       k;
    int       items_sent;
    int       set_size;
    int       mode;
    int       pick;
    dir_row_t r;
    rst          = 1'b1;
    in_valid     = 1'b0;
    value        = '0;
    last         = 1'b0;
    set_len      = 0;
    set_dropped  = 1'b0;
    error_count  = 0;
    tail_phase   = 1'b0;
    long_hold_go = 1'b0;

    // Single-value sets come straight back, so their results are written here.
    add_row(MOST_NEG, 1'b1, 1'b1, MOST_NEG);
    add_row(MOST_POS, 1'b1, 1'b1, MOST_POS);
    add_row('0,       1'b1, 1'b1, '0);
    add_row('1,       1'b1, 1'b1, '1);
    // Equal values around a smaller one.
    add_row(32'sd7,  1'b0, 1'b0, '0);
    add_row(-32'sd3, 1'b0, 1'b0, '0);
    add_row(32'sd7,  1'b1, 1'b0, '0);
    // Set one past capacity, descending over its kept beats, the last mark on the dropped beat.
    for (k = 0; k <= CAPACITY; k++) begin
      add_row(k == 0 ? MOST_POS : (k == CAPACITY - 1 ? MOST_NEG : 100 * (CAPACITY - k) - 800),
              k == CAPACITY, 1'b0, '0);
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_beat(r.value, r.last, r.fixed_exp, r.want);
    end

    // Mostly small sets, now and then a full or an overflowing one.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) set_size = $urandom_range(1, 6);
      else if (pick == 7) set_size = $urandom_range(7, CAPACITY);
      else if (pick == 8) set_size = CAPACITY;
      else set_size = $urandom_range(CAPACITY + 1, CAPACITY + 4);
      mode = $urandom_range(0, 3);
      for (k = 0; k < set_size; k++) begin
        if (items_sent >= TAIL_START) tail_phase = 1'b1;
        if (items_sent >= HOLD_AT_ITEM) long_hold_go = 1'b1;
        send_beat(pick_value(mode), k == set_size - 1, 1'b0, '0);
        items_sent++;
      end
    end
    in_valid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: short random hold-offs, and one long one that holds the sorter
  // on its results, so that it refuses input while the sender keeps offering beats.
  initial begin
    int  hold_cnt;
    bit  long_hold_done;
    hold_cnt       = 0;
    long_hold_done = 1'b0;
    out_ready      = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (long_hold_go && !long_hold_done) begin
        long_hold_done = 1'b1;
        hold_cnt = LONG_HOLD;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 7) == 0) begin
        hold_cnt = $urandom_range(1, 5) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    sorted_beat_t b;
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat, sorted_value", sorted_value, '0);
      end else begin
        b = expected_beats.pop_front();
        if (sorted_value !== b.value) report_mismatch("sorted_value", sorted_value, b.value);
        if (final_res !== b.fin) report_mismatch("final_res", final_res, b.fin);
        if (overflow !== b.ovf) report_mismatch("overflow", overflow, b.ovf);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout after %0d cycles with no beat", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

>>> files.f
sv/oets_pkg.sv
sv/oets_ram.sv
sv/oets_cmp.sv
sv/odd_even_transposition_sorter.sv
verif/tb_odd_even_transposition_sorter.sv
